/* rtl/core/spf_pkg.sv */
// Package for the shortest path finder: sizes, codes and state encodings.
// No dependencies.
`default_nettype none
package spf_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;
  localparam int WeightBits  = 16;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);
  localparam int DistW = 23;
  localparam logic [DistW-1:0] DistInf = '1;
  localparam logic [DistW-1:0] DistMax = 23'h3FFFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SCAN, ST_SCAN_END, ST_EDGE, ST_EDGE_END,
    ST_WALK, ST_WALK_WAIT, ST_FETCH, ST_EMIT, ST_FAIL
  } state_t;
endpackage
`default_nettype wire

/* rtl/core/shortest_path_finder.sv */
// Shortest path finder top level: edge memory, vertex memory and the
// sequencer that runs the search. Uses spf_pkg.
`default_nettype none
// Clear and add beats may arrive back to back. A query stalls the input through
// table init of all 64 vertex entries, then per round a minimum scan through the
// vertex memory plus, unless the chosen vertex is the target, an edge scan over
// all stored edges (one edge memory read per cycle), at most n-1 rounds. The
// parent walk then follows the parent links back from the target, one path vertex
// at a time, followed by a fetch state and the result beats, which are emitted
// while the output is free. Results leave through a one-beat output register; the
// emission holds while the output is stalled.
module shortest_path_finder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_vertex_count,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [5:0]  in_src_vertex,
  input  wire logic [5:0]  in_dst_vertex,
  input  wire logic [15:0] in_edge_weight,
  input  wire logic [5:0]  in_start_vertex,
  input  wire logic [5:0]  in_end_vertex,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       out_path_vertex,
  output logic [21:0]      out_total_distance,
  output logic             out_found,
  output logic             out_is_last,
  output logic             out_table_overflow
);
  localparam int VW = spf_pkg::VW;
  localparam int EW = spf_pkg::EW;
  localparam int DW = spf_pkg::DistW;
  localparam int WB = spf_pkg::WeightBits;
  localparam int EntW = 2*VW + WB;

  logic [6:0] vcount_r;
  logic [VW:0] n_w;
  assign n_w = (vcount_r > 7'(spf_pkg::MaxVertices)) ? (VW+1)'(spf_pkg::MaxVertices)
                                                     : vcount_r[VW:0];

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'(spf_pkg::MaxVertices);
    else if (cfg_we) vcount_r <= cfg_vertex_count;
  end

  // Edge memory.
  logic [EntW-1:0] emem [spf_pkg::MaxEdges];
  logic [EntW-1:0] erd_r;
  logic [EW-1:0]   eaddr;
  logic            ewe;
  logic [EntW-1:0] ewd;
  always_ff @(posedge clk) begin
    if (ewe) emem[eaddr] <= ewd;
    erd_r <= emem[eaddr];
  end

  // Vertex memory: {visited, parent, dist}, one read and one write port.
  localparam int VEW = 1 + VW + 1 + DW;
  logic [VEW-1:0] vmem [spf_pkg::MaxVertices];
  logic [VEW-1:0] vrd_r;
  logic [VW-1:0]  vaddr;
  logic [VW-1:0]  vwaddr;
  logic           vwe;
  logic [VEW-1:0] vwd;
  always_ff @(posedge clk) begin
    if (vwe) vmem[vwaddr] <= vwd;
    vrd_r <= vmem[vaddr];
  end
  logic          rd_vis;
  logic [VW:0]   rd_par;
  logic [DW-1:0] rd_dist;
  assign {rd_vis, rd_par, rd_dist} = vrd_r;

  spf_pkg::state_t st_r, st_nxt;
  logic [EW:0]   fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [VW-1:0] start_r, start_nxt, end_r, end_nxt;
  logic [VW:0]   idx_r, idx_nxt;      // vertex index / walk pointer
  logic [EW:0]   eidx_r, eidx_nxt;
  logic [VW:0]   round_r, round_nxt;
  logic [VW:0]   u_r, u_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic [VW:0]   bpar_r, bpar_nxt;
  logic [VW:0]   len_r, len_nxt;
  logic [DW-1:0] tdist_r, tdist_nxt;
  logic [VW-1:0] path_r [spf_pkg::MaxVertices];
  logic [VW-1:0] prd_r;
  logic [VW-1:0] praddr;
  logic [VW:0]   plast;
  logic          pwe;
  logic [VW:0]   pcnt_r, pcnt_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt, of_r, of_nxt, oo_r, oo_nxt;
  logic [VW-1:0] ov_vtx_r, ov_vtx_nxt;
  logic [DW-1:0] ov_d_r, ov_d_nxt;
  logic          rvld_r, rvld_nxt;    // vertex read in flight during scan
  logic [VW:0]   ridx_r, ridx_nxt;
  logic          erv_r, erv_nxt;

  // Relaxation candidate from the registered edge read.
  logic [VW-1:0] e_src, e_dst;
  logic [WB-1:0] e_w;
  assign {e_src, e_dst, e_w} = erd_r;
  logic [DW:0] sum;
  logic [DW-1:0] nd;
  assign sum = {1'b0, best_r} + (DW+1)'(e_w);
  assign nd  = (sum > (DW+1)'(spf_pkg::DistMax)) ? spf_pkg::DistMax : sum[DW-1:0];

  // Edge scan pipeline: cycle A reads edge, cycle B reads vertex dst, cycle C relaxes.
  logic          rel_v_r, rel_v_nxt;
  logic [VW-1:0] rel_d_r, rel_d_nxt;
  logic [DW-1:0] rel_nd_r, rel_nd_nxt;

  // A write in the previous cycle is not yet visible in the vertex read.
  logic          fwd_v_r, fwd_v_nxt;
  logic [VW-1:0] fwd_a_r, fwd_a_nxt;
  logic [DW-1:0] fwd_d_r, fwd_d_nxt;
  logic [DW-1:0] c_dist;
  assign c_dist = (fwd_v_r && fwd_a_r == rel_d_r) ? fwd_d_r : rd_dist;

  logic out_free;
  assign out_free = !ov_r || !out_stall;

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; ovf_nxt = ovf_r;
    start_nxt = start_r; end_nxt = end_r; idx_nxt = idx_r; eidx_nxt = eidx_r;
    round_nxt = round_r; u_nxt = u_r; best_nxt = best_r; len_nxt = len_r;
    bpar_nxt = bpar_r;
    tdist_nxt = tdist_r; pcnt_nxt = pcnt_r;
    ov_nxt = ov_r && out_stall; ol_nxt = ol_r; of_nxt = of_r; oo_nxt = oo_r;
    ov_vtx_nxt = ov_vtx_r; ov_d_nxt = ov_d_r;
    rvld_nxt = 1'b0; ridx_nxt = ridx_r; erv_nxt = 1'b0;
    rel_v_nxt = 1'b0; rel_d_nxt = rel_d_r; rel_nd_nxt = rel_nd_r;
    fwd_v_nxt = 1'b0; fwd_a_nxt = fwd_a_r; fwd_d_nxt = fwd_d_r;
    in_stall = 1'b1;
    eaddr = fill_r[EW-1:0]; ewe = 1'b0;
    ewd = {in_src_vertex[VW-1:0], in_dst_vertex[VW-1:0], in_edge_weight[WB-1:0]};
    vaddr = idx_r[VW-1:0]; vwaddr = idx_r[VW-1:0]; vwe = 1'b0; vwd = vrd_r; pwe = 1'b0;
    case (st_r)
      spf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (spf_pkg::func_t'(in_func))
            spf_pkg::FUNC_CLEAR: begin fill_nxt = '0; ovf_nxt = 1'b0; end
            spf_pkg::FUNC_ADD: begin
              if ((VW+1)'(in_src_vertex) < n_w && (VW+1)'(in_dst_vertex) < n_w) begin
                if (fill_r >= (EW+1)'(spf_pkg::MaxEdges)) ovf_nxt = 1'b1;
                else begin ewe = 1'b1; fill_nxt = fill_r + 1'b1; end
              end
            end
            spf_pkg::FUNC_QUERY: begin
              start_nxt = in_start_vertex[VW-1:0]; end_nxt = in_end_vertex[VW-1:0];
              idx_nxt = '0; round_nxt = '0; st_nxt = spf_pkg::ST_INIT;
            end
            default: ;
          endcase
        end
      end
      spf_pkg::ST_INIT: begin
        vwe = 1'b1;
        vwd = {1'b0, {(VW+1){1'b1}},
               (idx_r[VW-1:0] == start_r) ? {DW{1'b0}} : spf_pkg::DistInf};
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (VW+1)'(spf_pkg::MaxVertices - 1)) begin
          idx_nxt = '0;
          if ((VW+1)'(start_r) >= n_w || (VW+1)'(end_r) >= n_w) st_nxt = spf_pkg::ST_FAIL;
          else if (n_w < (VW+1)'(2)) st_nxt = spf_pkg::ST_WALK;
          else begin
            best_nxt = spf_pkg::DistInf; u_nxt = (VW+1)'(spf_pkg::MaxVertices);
            st_nxt = spf_pkg::ST_SCAN;
          end
        end
      end
      spf_pkg::ST_SCAN, spf_pkg::ST_SCAN_END: begin
        if (st_r == spf_pkg::ST_SCAN) begin
          rvld_nxt = 1'b1; ridx_nxt = idx_r; idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 >= n_w) st_nxt = spf_pkg::ST_SCAN_END;
        end
        if (rvld_r && !rd_vis && rd_dist < best_r) begin
          best_nxt = rd_dist; u_nxt = ridx_r; bpar_nxt = rd_par;
        end
        if (st_r == spf_pkg::ST_SCAN_END && !rvld_r) begin
          if (u_r >= n_w) st_nxt = spf_pkg::ST_WALK;
          else begin
            // Mark the chosen vertex visited, keeping its distance and parent.
            vwaddr = u_r[VW-1:0]; vwe = 1'b1;
            vwd = {1'b1, bpar_r, best_r};
            st_nxt = spf_pkg::ST_EDGE_END;
            idx_nxt = u_r;
            if (u_r[VW-1:0] == end_r) st_nxt = spf_pkg::ST_WALK;
            else begin eidx_nxt = '0; st_nxt = spf_pkg::ST_EDGE; end
          end
        end else if (st_r == spf_pkg::ST_SCAN_END) begin
          vaddr = ridx_r[VW-1:0];
        end
        if (st_r == spf_pkg::ST_SCAN) vaddr = idx_r[VW-1:0];
      end
      spf_pkg::ST_EDGE, spf_pkg::ST_EDGE_END: begin
        // Stage A: read edge.
        if (st_r == spf_pkg::ST_EDGE) begin
          eaddr = eidx_r[EW-1:0];
          if (eidx_r >= fill_r) st_nxt = spf_pkg::ST_EDGE_END;
          else begin erv_nxt = 1'b1; eidx_nxt = eidx_r + 1'b1; end
        end
        // Stage B: edge data ready, read destination vertex.
        vaddr = e_dst;
        if (erv_r && e_src == u_r[VW-1:0] && (VW+1)'(e_dst) < n_w) begin
          rel_v_nxt = 1'b1; rel_d_nxt = e_dst; rel_nd_nxt = nd;
        end
        // Stage C: compare and write; forward the write from the previous cycle.
        if (rel_v_r) begin
          if (!rd_vis && rel_nd_r < c_dist) begin
            vwaddr = rel_d_r; vwe = 1'b1;
            vwd = {1'b0, u_r, rel_nd_r};
            fwd_v_nxt = 1'b1; fwd_a_nxt = rel_d_r; fwd_d_nxt = rel_nd_r;
          end
        end
        if (st_r == spf_pkg::ST_EDGE_END && !erv_r && !rel_v_r) begin
          round_nxt = round_r + 1'b1;
          if (round_r + 1'b1 + 1'b1 >= n_w) st_nxt = spf_pkg::ST_WALK;
          else begin
            idx_nxt = '0; best_nxt = spf_pkg::DistInf;
            u_nxt = (VW+1)'(spf_pkg::MaxVertices); st_nxt = spf_pkg::ST_SCAN;
          end
        end
      end
      spf_pkg::ST_WALK: begin
        vaddr = end_r; idx_nxt = (VW+1)'(end_r); len_nxt = '0;
        st_nxt = spf_pkg::ST_WALK_WAIT; pcnt_nxt = '0;
      end
      spf_pkg::ST_WALK_WAIT: begin
        // rd is vertex idx_r.
        if (pcnt_r == '0) begin
          tdist_nxt = rd_dist;
          if (rd_dist == spf_pkg::DistInf) st_nxt = spf_pkg::ST_FAIL;
        end
        if (!(pcnt_r == '0 && rd_dist == spf_pkg::DistInf)) begin
          pwe = 1'b1; len_nxt = len_r + 1'b1; pcnt_nxt = pcnt_r + 1'b1;
          vaddr = rd_par[VW-1:0];
          if (rd_par[VW] || len_r + 1'b1 >= n_w) st_nxt = spf_pkg::ST_FETCH;
          else idx_nxt = rd_par;
        end
      end
      spf_pkg::ST_FETCH: st_nxt = spf_pkg::ST_EMIT;
      spf_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1; of_nxt = 1'b1; ov_vtx_nxt = prd_r; oo_nxt = ovf_r;
          ov_d_nxt = tdist_r; ol_nxt = (len_r == (VW+1)'(1));
          len_nxt = len_r - 1'b1;
          if (len_r == (VW+1)'(1)) st_nxt = spf_pkg::ST_IDLE;
        end
      end
      spf_pkg::ST_FAIL: begin
        if (out_free) begin
          ov_nxt = 1'b1; of_nxt = 1'b0; ov_vtx_nxt = '0; ov_d_nxt = '0; ol_nxt = 1'b1;
          oo_nxt = ovf_r;
          st_nxt = spf_pkg::ST_IDLE;
        end
      end
      default: st_nxt = spf_pkg::ST_IDLE;
    endcase
    // The path memory read runs one beat ahead of the emission.
    plast = len_nxt - 1'b1;
    praddr = plast[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pwe) path_r[len_r[VW-1:0]] <= idx_r[VW-1:0];
    prd_r <= path_r[praddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= spf_pkg::ST_IDLE; fill_r <= '0; ovf_r <= 1'b0; ov_r <= 1'b0;
      rvld_r <= 1'b0; erv_r <= 1'b0; rel_v_r <= 1'b0; fwd_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; ovf_r <= ovf_nxt; ov_r <= ov_nxt;
      rvld_r <= rvld_nxt; erv_r <= erv_nxt; rel_v_r <= rel_v_nxt; fwd_v_r <= fwd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt; end_r <= end_nxt; idx_r <= idx_nxt; eidx_r <= eidx_nxt;
    round_r <= round_nxt; u_r <= u_nxt; best_r <= best_nxt; len_r <= len_nxt;
    bpar_r <= bpar_nxt;
    tdist_r <= tdist_nxt; pcnt_r <= pcnt_nxt; ol_r <= ol_nxt; of_r <= of_nxt;
    oo_r <= oo_nxt;
    ov_vtx_r <= ov_vtx_nxt; ov_d_r <= ov_d_nxt; ridx_r <= ridx_nxt;
    rel_d_r <= rel_d_nxt; rel_nd_r <= rel_nd_nxt;
    fwd_a_r <= fwd_a_nxt; fwd_d_r <= fwd_d_nxt;
  end

  assign out_valid          = ov_r;
  assign out_path_vertex    = ov_vtx_r;
  assign out_total_distance = ov_d_r[21:0];
  assign out_found          = of_r;
  assign out_is_last        = ol_r;
  assign out_table_overflow = oo_r;
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the shortest path finder: drives edge loads,
// clears and path queries and compares every result beat with a predictor.
// Depends on spf_pkg and shortest_path_finder.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  vertex;
    logic [21:0] distance;
    logic        found;
    logic        last;
    logic        ovf;
  } path_beat_t;

  class path_scoreboard;
    logic [5:0]  e_src[spf_pkg::MaxEdges];
    logic [5:0]  e_dst[spf_pkg::MaxEdges];
    logic [15:0] e_wgt[spf_pkg::MaxEdges];
    int unsigned fill;
    bit          ovf;
    int unsigned vcount;
    path_beat_t  pending[$];
    int          mismatches;

    function void reset_state();
      fill = 0;
      ovf = 0;
      vcount = 64;
      pending.delete();
      mismatches = 0;
    endfunction

    function int unsigned active_n();
      return (vcount > spf_pkg::MaxVertices) ? spf_pkg::MaxVertices : vcount;
    endfunction

    function void push_miss();
      path_beat_t b;
      b = '{vertex: '0, distance: '0, found: 1'b0, last: 1'b1, ovf: ovf};
      pending.push_back(b);
    endfunction

    function void solve_path(int unsigned s, int unsigned t);
      logic [22:0] dtab[spf_pkg::MaxVertices];
      bit          seen[spf_pkg::MaxVertices];
      logic [6:0]  par[spf_pkg::MaxVertices];
      logic [5:0]  route[$];
      int unsigned n, u, cur;
      logic [22:0] best;
      logic [23:0] nd;
      path_beat_t  b;
      n = active_n();
      for (int i = 0; i < spf_pkg::MaxVertices; i++) begin
        dtab[i] = spf_pkg::DistInf;
        seen[i] = 0;
        par[i] = 7'h7f;
      end
      if (s >= n || t >= n) begin
        push_miss();
        return;
      end
      dtab[s] = 0;
      for (int r = 0; r + 1 < n; r++) begin
        best = spf_pkg::DistInf;
        u = spf_pkg::MaxVertices;
        for (int i = 0; i < n; i++)
          if (!seen[i] && dtab[i] < best) begin
            best = dtab[i];
            u = i;
          end
        if (u >= n) break;
        seen[u] = 1;
        if (u == t) break;
        for (int e = 0; e < fill; e++) begin
          if (e_src[e] != u || e_dst[e] >= n || seen[e_dst[e]]) continue;
          nd = 24'(dtab[u]) + 24'(e_wgt[e]);
          if (nd > 24'(spf_pkg::DistMax)) nd = 24'(spf_pkg::DistMax);
          if (nd[22:0] < dtab[e_dst[e]]) begin
            dtab[e_dst[e]] = nd[22:0];
            par[e_dst[e]] = 7'(u);
          end
        end
      end
      if (dtab[t] == spf_pkg::DistInf) begin
        push_miss();
        return;
      end
      cur = t;
      while (cur < spf_pkg::MaxVertices && route.size() < n) begin
        route.push_front(cur[5:0]);
        cur = par[cur];
      end
      foreach (route[k]) begin
        b = '{vertex: route[k], distance: dtab[t][21:0], found: 1'b1,
              last: (k == route.size() - 1), ovf: ovf};
        pending.push_back(b);
      end
    endfunction

    function void note_beat(spf_pkg::func_t f, logic [5:0] s, logic [5:0] d,
                            logic [15:0] w, logic [5:0] qs, logic [5:0] qe);
      case (f)
        spf_pkg::FUNC_CLEAR: begin
          fill = 0;
          ovf = 0;
        end
        spf_pkg::FUNC_ADD: begin
          if (s < active_n() && d < active_n()) begin
            if (fill >= spf_pkg::MaxEdges) ovf = 1;
            else begin
              e_src[fill] = s;
              e_dst[fill] = d;
              e_wgt[fill] = w;
              fill++;
            end
          end
        end
        spf_pkg::FUNC_QUERY: solve_path(qs, qe);
        default: ;
      endcase
    endfunction

    function void check_beat(path_beat_t got);
      path_beat_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [6:0]  cfg_vertex_count = 64;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_func = spf_pkg::FUNC_NONE;
  logic [5:0]  in_src_vertex = 0, in_dst_vertex = 0, in_start_vertex = 0, in_end_vertex = 0;
  logic [15:0] in_edge_weight = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [5:0]  out_path_vertex;
  logic [21:0] out_total_distance;
  logic        out_found, out_is_last, out_table_overflow;

  shortest_path_finder i_dut (
    .clk, .rst_n, .cfg_we, .cfg_vertex_count,
    .in_valid, .in_stall, .in_func, .in_src_vertex, .in_dst_vertex,
    .in_edge_weight, .in_start_vertex, .in_end_vertex,
    .out_valid, .out_stall, .out_path_vertex, .out_total_distance,
    .out_found, .out_is_last, .out_table_overflow
  );

  always #6 clk = ~clk;

  path_scoreboard board = new();
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_beat(path_beat_t'{out_path_vertex, out_total_distance, out_found,
                                      out_is_last, out_table_overflow});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles > 200000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drives one beat, honoring the sender idle rate, and returns once accepted.
  // Valid stays up after the accepting edge until the next beat or an idle cycle.
  task automatic send_beat(spf_pkg::func_t f, logic [5:0] s, logic [5:0] d,
                           logic [15:0] w, logic [5:0] qs, logic [5:0] qe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_src_vertex <= s;
    in_dst_vertex <= d;
    in_edge_weight <= w;
    in_start_vertex <= qs;
    in_end_vertex <= qe;
    do @(posedge clk); while (in_stall);
    board.note_beat(f, s, d, w, qs, qe);
  endtask

  task automatic add_edge(int s, int d, int w);
    send_beat(spf_pkg::FUNC_ADD, 6'(s), 6'(d), 16'(w), 6'($urandom), 6'($urandom));
  endtask

  task automatic query(int s, int e);
    send_beat(spf_pkg::FUNC_QUERY, 6'($urandom), 6'($urandom), 16'($urandom),
              6'(s), 6'(e));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertex_count(int n);
    drain();
    cfg_we <= 1;
    cfg_vertex_count <= 7'(n);
    @(posedge clk);
    cfg_we <= 0;
    board.vcount = n;
  endtask

  // A random graph followed by queries; mostly edges within the active range.
  task automatic random_graph(int edges, int queries);
    int n;
    n = board.active_n();
    send_beat(spf_pkg::FUNC_CLEAR, 6'($urandom), 6'($urandom), 16'($urandom),
              6'($urandom), 6'($urandom));
    repeat (edges) begin
      if ($urandom_range(9) == 0)
        send_beat(spf_pkg::func_t'(2'($urandom_range(3))), 6'($urandom), 6'($urandom),
                  16'($urandom), 6'($urandom), 6'($urandom));
      else
        add_edge($urandom_range(n - 1), $urandom_range(n - 1),
                 $urandom_range(3) == 0 ? $urandom : $urandom_range(40));
    end
    repeat (queries)
      query($urandom_range(n - 1), $urandom_range(4) == 0 ? $urandom : $urandom_range(n - 1));
  endtask

  initial begin
    board.reset_state();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: chain with ties, start equals end, unreachable, ignored edges.
    set_vertex_count(8);
    add_edge(0, 1, 65535);
    add_edge(1, 2, 65535);
    add_edge(0, 2, 16'hffff);
    add_edge(2, 3, 0);
    add_edge(0, 3, 65535 * 2 > 0 ? 65535 : 0);
    add_edge(9, 1, 5);
    add_edge(1, 63, 5);
    send_beat(spf_pkg::FUNC_NONE, 6'h3f, 6'h3f, 16'hffff, 6'h3f, 6'h3f);
    query(0, 3);
    query(0, 0);
    query(3, 0);
    query(0, 63);
    query(63, 0);
    set_vertex_count(64);
    add_edge(63, 62, 4000000 % 65536);
    query(63, 62);
    set_vertex_count(2);
    query(0, 1);
    query(1, 0);
    set_vertex_count(1);
    query(0, 0);
    add_edge(0, 0, 7);
    set_vertex_count(64);
    send_beat(spf_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0);
    add_edge(1, 2, 3);
    query(1, 2);
    query(0, 5);

    send_idle_pct = 11;
    recv_idle_pct = 49;
    set_vertex_count(10);
    random_graph(14, 5);
    set_vertex_count(127);
    random_graph(14, 4);
    send_idle_pct = 49;
    recv_idle_pct = 11;
    set_vertex_count(5);
    random_graph(12, 8);
    drain();
    set_vertex_count(16);
    random_graph(12, 5);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_vertex_count(3);
    random_graph(8, 6);
    set_vertex_count(64);
    random_graph(12, 4);
    drain();

    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
